@@ hw/rtl/arm_dp_pkg.sv @@
`default_nettype none

package arm_dp_pkg;

    // Field widths of the block.
    localparam int WORD_W  = 32;
    localparam int REG_N   = 16;
    localparam int REG_W   = 4;
    localparam int FLAGS_W = 4;

    // Bit positions in the status flags.
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // Item kinds.
    typedef enum logic [1:0] {
        ACT_EXECUTE = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_READ    = 2'd2
    } t_action;

    // Condition field codes.
    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } t_cond;

    // Supported data-processing opcodes.
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13
    } t_opcode;

    // Barrel shifter operations.
    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } t_shift;

    // Outcome of one instruction in the ALU.
    typedef struct packed {
        logic                executed;
        logic                write;
        logic [WORD_W-1:0]   result;
        logic [FLAGS_W-1:0]  flags;
    } t_alu_out;

endpackage

`default_nettype wire

@@ hw/rtl/arm_dp_ram.sv @@
`default_nettype none

module arm_dp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]              o_rd_data_a,
    output logic [WIDTH-1:0]              o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // One write port and two registered read ports; a read sees the old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

@@ hw/rtl/arm_dp_shifter.sv @@
`default_nettype none

module arm_dp_shifter (
    input  wire logic        i_imm_form,
    input  wire logic [11:0] i_operand2,
    input  wire logic [31:0] i_rm_value,
    input  wire logic [31:0] i_rs_value,
    output logic [31:0]      o_value,
    output logic             o_carry
);

    arm_dp_pkg::t_shift shift_op;
    logic [7:0]         amount;
    logic [31:0]        base;
    logic [4:0]         amt_m1;
    logic [4:0]         amt_neg;
    logic [63:0]        rotated;

    // Pick the source value, the operation and the amount.
    always_comb begin
        if (i_imm_form) begin
            base     = {24'd0, i_operand2[7:0]};
            shift_op = arm_dp_pkg::SHIFT_ROR;
            amount   = {3'd0, i_operand2[11:8], 1'b0};
        end else begin
            base     = i_rm_value;
            shift_op = arm_dp_pkg::t_shift'(i_operand2[6:5]);
            if (i_operand2[4]) begin
                amount = i_rs_value[7:0];
            end else begin
                amount = {3'd0, i_operand2[11:7]};
            end
        end
    end

    assign amt_m1  = amount[4:0] - 5'd1;
    assign amt_neg = 5'd0 - amount[4:0];
    assign rotated = {base, base} >> amount[4:0];

    // Barrel shift with the carry out; an amount of zero passes the value with carry clear.
    always_comb begin
        o_value = base;
        o_carry = 1'b0;
        if (amount != 8'd0) begin
            case (shift_op)
                arm_dp_pkg::SHIFT_LSL: begin
                    if (amount < 8'd32) begin
                        o_value = base << amount[4:0];
                        o_carry = base[amt_neg];
                    end else begin
                        o_value = 32'd0;
                        o_carry = (amount == 8'd32) ? base[0] : 1'b0;
                    end
                end
                arm_dp_pkg::SHIFT_LSR: begin
                    if (amount < 8'd32) begin
                        o_value = base >> amount[4:0];
                        o_carry = base[amt_m1];
                    end else begin
                        o_value = 32'd0;
                        o_carry = (amount == 8'd32) ? base[31] : 1'b0;
                    end
                end
                arm_dp_pkg::SHIFT_ASR: begin
                    if (amount < 8'd32) begin
                        o_value = 32'($signed(base) >>> amount[4:0]);
                        o_carry = base[amt_m1];
                    end else begin
                        o_value = {32{base[31]}};
                        o_carry = base[31];
                    end
                end
                arm_dp_pkg::SHIFT_ROR: begin
                    if (amount[4:0] == 5'd0) begin
                        o_value = base;
                        o_carry = base[31];
                    end else begin
                        o_value = rotated[31:0];
                        o_carry = base[amt_m1];
                    end
                end
                default: begin
                    o_value = base;
                    o_carry = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/arm_dp_alu.sv @@
`default_nettype none

module arm_dp_alu (
    input  wire logic [31:0]      i_instr,
    input  wire logic [31:0]      i_rn_value,
    input  wire logic [31:0]      i_op2,
    input  wire logic             i_shift_carry,
    input  wire logic [3:0]       i_flags,
    output arm_dp_pkg::t_alu_out  o_alu
);

    arm_dp_pkg::t_opcode opcode;
    logic                pass;
    logic                flag_n;
    logic                flag_z;
    logic                flag_c;
    logic                flag_v;
    logic                is_sub;
    logic                is_rsb;
    logic [31:0]         add_a;
    logic [31:0]         add_b;
    logic [32:0]         sum;
    logic [31:0]         res;
    logic                write;
    logic                setf;
    logic                fc;

    assign opcode = arm_dp_pkg::t_opcode'(i_instr[24:21]);
    assign flag_n = i_flags[arm_dp_pkg::FLAG_N];
    assign flag_z = i_flags[arm_dp_pkg::FLAG_Z];
    assign flag_c = i_flags[arm_dp_pkg::FLAG_C];
    assign flag_v = i_flags[arm_dp_pkg::FLAG_V];

    // Condition check against the current flags.
    always_comb begin
        case (arm_dp_pkg::t_cond'(i_instr[31:28]))
            arm_dp_pkg::COND_EQ: pass = flag_z;
            arm_dp_pkg::COND_NE: pass = !flag_z;
            arm_dp_pkg::COND_CS: pass = flag_c;
            arm_dp_pkg::COND_CC: pass = !flag_c;
            arm_dp_pkg::COND_MI: pass = flag_n;
            arm_dp_pkg::COND_PL: pass = !flag_n;
            arm_dp_pkg::COND_VS: pass = flag_v;
            arm_dp_pkg::COND_VC: pass = !flag_v;
            arm_dp_pkg::COND_HI: pass = flag_c && !flag_z;
            arm_dp_pkg::COND_LS: pass = !flag_c || flag_z;
            arm_dp_pkg::COND_GE: pass = (flag_n == flag_v);
            arm_dp_pkg::COND_LT: pass = (flag_n != flag_v);
            arm_dp_pkg::COND_GT: pass = !flag_z && (flag_n == flag_v);
            arm_dp_pkg::COND_LE: pass = flag_z || (flag_n != flag_v);
            arm_dp_pkg::COND_AL: pass = 1'b1;
            default:             pass = 1'b0;
        endcase
    end

    // One shared adder; subtracts add the inverted operand, so the carry out means no borrow.
    assign is_rsb = (opcode == arm_dp_pkg::OP_RSB);
    assign is_sub = is_rsb || (opcode == arm_dp_pkg::OP_SUB) || (opcode == arm_dp_pkg::OP_CMP);
    assign add_a  = is_rsb ? i_op2 : i_rn_value;
    assign add_b  = is_rsb ? i_rn_value : i_op2;
    assign sum    = {1'b0, add_a} + {1'b0, (is_sub ? ~add_b : add_b)} + {32'd0, is_sub};

    // Operation select.
    always_comb begin
        res   = 32'd0;
        write = 1'b0;
        setf  = 1'b0;
        fc    = 1'b0;
        case (opcode)
            arm_dp_pkg::OP_AND: begin
                res = i_rn_value & i_op2; write = 1'b1; setf = i_instr[20]; fc = i_shift_carry;
            end
            arm_dp_pkg::OP_EOR: begin
                res = i_rn_value ^ i_op2; write = 1'b1; setf = i_instr[20]; fc = i_shift_carry;
            end
            arm_dp_pkg::OP_TST: begin
                res = i_rn_value & i_op2; setf = i_instr[20]; fc = i_shift_carry;
            end
            arm_dp_pkg::OP_TEQ: begin
                res = i_rn_value ^ i_op2; setf = i_instr[20]; fc = i_shift_carry;
            end
            arm_dp_pkg::OP_ORR: begin
                res = i_rn_value | i_op2; write = 1'b1; setf = i_instr[20]; fc = i_shift_carry;
            end
            arm_dp_pkg::OP_MOV: begin
                res = i_op2; write = 1'b1; setf = i_instr[20]; fc = i_shift_carry;
            end
            arm_dp_pkg::OP_ADD, arm_dp_pkg::OP_SUB, arm_dp_pkg::OP_RSB: begin
                res = sum[31:0]; write = 1'b1; setf = i_instr[20]; fc = sum[32];
            end
            arm_dp_pkg::OP_CMP: begin
                res = sum[31:0]; setf = i_instr[20]; fc = sum[32];
            end
            default: begin
                res   = 32'd0;
                write = 1'b0;
                setf  = 1'b0;
                fc    = 1'b0;
            end
        endcase
    end

    // A failed condition leaves everything as it was.
    always_comb begin
        o_alu.executed = pass;
        o_alu.write    = pass && write;
        o_alu.result   = pass ? res : 32'd0;
        o_alu.flags    = i_flags;
        if (pass && setf) begin
            o_alu.flags[arm_dp_pkg::FLAG_N] = res[31];
            o_alu.flags[arm_dp_pkg::FLAG_Z] = (res == 32'd0);
            o_alu.flags[arm_dp_pkg::FLAG_C] = fc;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/arm_dp_execute.sv @@
`default_nettype none

// Data-processing execute unit with a 16 x 32 register file and NZCV flags. Each
// transfer either executes one instruction, loads a register or reads one, and
// gives exactly one result transfer. The unit takes one item per cycle while
// o_stall is low. The input transfer reads Rn, Rm and Rs (or the selected
// register) from two synchronous register-file RAMs; the execute stage then
// runs the shifter and ALU, writes the RAM and fills the output register.
// A write by the item ahead is forwarded to the reads of the next item. Reset
// clears the flags and a valid bit per register, so every register reads zero
// until it is written; there is no clearing pass.
module arm_data_processing_execute (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [3:0]  i_reg_select,
    input  wire logic [31:0] i_load_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_executed,
    output logic             o_wrote_register,
    output logic [3:0]       o_dest_index,
    output logic [31:0]      o_result_value,
    output logic             o_flag_n,
    output logic             o_flag_z,
    output logic             o_flag_c,
    output logic             o_flag_v,
    output logic [31:0]      o_read_data
);

    // Handshake and pipeline control.
    logic in_fire;
    logic e_adv;
    logic e_fire;

    // Execute stage.
    logic                r_e_valid;
    arm_dp_pkg::t_action r_e_action;
    logic [31:0]         r_e_instr;
    logic [3:0]          r_e_sel;
    logic [31:0]         r_e_ldv;
    logic                r_e_hit_rn, r_e_hit_rm, r_e_hit_rs, r_e_hit_sel;
    logic                r_e_vld_rn, r_e_vld_rm, r_e_vld_rs, r_e_vld_sel;
    logic [31:0]         r_e_fwd;

    // Register file and flags.
    logic [arm_dp_pkg::REG_N-1:0]   r_reg_valid;
    logic [arm_dp_pkg::FLAGS_W-1:0] r_flags;
    logic [arm_dp_pkg::FLAGS_W-1:0] n_flags;
    logic                           ram_wr_en;
    logic [3:0]                     ram_wr_addr;
    logic [31:0]                    ram_wr_data;
    logic [31:0]                    ram_rn, ram_rm, ram_rs, ram_sel;
    logic [31:0]                    rn_val, rm_val, rs_val, sel_val;

    // Shifter and ALU.
    logic                  op2_carry;
    logic [31:0]           op2;
    arm_dp_pkg::t_alu_out  alu;

    // Result of the item in the execute stage.
    logic        n_executed;
    logic        n_wrote;
    logic [3:0]  n_dest;
    logic [31:0] n_result;
    logic [31:0] n_rdata;

    // Output register.
    logic        r_o_valid;
    logic        r_o_executed;
    logic        r_o_wrote;
    logic [3:0]  r_o_dest;
    logic [31:0] r_o_result;
    logic [3:0]  r_o_flags;
    logic [31:0] r_o_rdata;

    // The execute stage moves on when the output register is free or being emptied.
    assign e_adv   = !r_o_valid || !i_stall;
    assign e_fire  = r_e_valid && e_adv;
    assign o_stall = r_e_valid && !e_adv;
    assign in_fire = i_valid && !o_stall;

    // Register file: Rn and Rm in one RAM, Rs and the selected register in the other.
    arm_dp_ram #(
        .WIDTH (arm_dp_pkg::WORD_W),
        .DEPTH (arm_dp_pkg::REG_N)
    ) u_ram_a (
        .i_clk       (i_clk),
        .i_wr_en     (ram_wr_en),
        .i_wr_addr   (ram_wr_addr),
        .i_wr_data   (ram_wr_data),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (i_instruction_word[19:16]),
        .i_rd_addr_b (i_instruction_word[3:0]),
        .o_rd_data_a (ram_rn),
        .o_rd_data_b (ram_rm)
    );

    arm_dp_ram #(
        .WIDTH (arm_dp_pkg::WORD_W),
        .DEPTH (arm_dp_pkg::REG_N)
    ) u_ram_b (
        .i_clk       (i_clk),
        .i_wr_en     (ram_wr_en),
        .i_wr_addr   (ram_wr_addr),
        .i_wr_data   (ram_wr_data),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (i_instruction_word[11:8]),
        .i_rd_addr_b (i_reg_select),
        .o_rd_data_a (ram_rs),
        .o_rd_data_b (ram_sel)
    );

    // Capture the item with its forwarding and valid information.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_e_hit_rn  <= 1'b0;
            r_e_hit_rm  <= 1'b0;
            r_e_hit_rs  <= 1'b0;
            r_e_hit_sel <= 1'b0;
        end else begin
            if (in_fire) begin
                r_e_valid   <= 1'b1;
                r_e_hit_rn  <= ram_wr_en && (ram_wr_addr == i_instruction_word[19:16]);
                r_e_hit_rm  <= ram_wr_en && (ram_wr_addr == i_instruction_word[3:0]);
                r_e_hit_rs  <= ram_wr_en && (ram_wr_addr == i_instruction_word[11:8]);
                r_e_hit_sel <= ram_wr_en && (ram_wr_addr == i_reg_select);
            end else if (e_adv) begin
                r_e_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_e_action  <= arm_dp_pkg::t_action'(i_action);
            r_e_instr   <= i_instruction_word;
            r_e_sel     <= i_reg_select;
            r_e_ldv     <= i_load_value;
            r_e_fwd     <= ram_wr_data;
            r_e_vld_rn  <= r_reg_valid[i_instruction_word[19:16]];
            r_e_vld_rm  <= r_reg_valid[i_instruction_word[3:0]];
            r_e_vld_rs  <= r_reg_valid[i_instruction_word[11:8]];
            r_e_vld_sel <= r_reg_valid[i_reg_select];
        end
    end

    // Operand values: forwarded write first, then RAM data, zero if never written.
    assign rn_val  = r_e_hit_rn  ? r_e_fwd : (r_e_vld_rn  ? ram_rn  : 32'd0);
    assign rm_val  = r_e_hit_rm  ? r_e_fwd : (r_e_vld_rm  ? ram_rm  : 32'd0);
    assign rs_val  = r_e_hit_rs  ? r_e_fwd : (r_e_vld_rs  ? ram_rs  : 32'd0);
    assign sel_val = r_e_hit_sel ? r_e_fwd : (r_e_vld_sel ? ram_sel : 32'd0);

    arm_dp_shifter u_shifter (
        .i_imm_form (r_e_instr[25]),
        .i_operand2 (r_e_instr[11:0]),
        .i_rm_value (rm_val),
        .i_rs_value (rs_val),
        .o_value    (op2),
        .o_carry    (op2_carry)
    );

    arm_dp_alu u_alu (
        .i_instr       (r_e_instr),
        .i_rn_value    (rn_val),
        .i_op2         (op2),
        .i_shift_carry (op2_carry),
        .i_flags       (r_flags),
        .o_alu         (alu)
    );

    // Result of the item by its kind.
    always_comb begin
        n_executed = 1'b0;
        n_wrote    = 1'b0;
        n_dest     = 4'd0;
        n_result   = 32'd0;
        n_rdata    = 32'd0;
        n_flags    = r_flags;
        case (r_e_action)
            arm_dp_pkg::ACT_EXECUTE: begin
                n_executed = alu.executed;
                n_wrote    = alu.write;
                n_dest     = alu.executed ? r_e_instr[15:12] : 4'd0;
                n_result   = alu.result;
                n_flags    = alu.flags;
            end
            arm_dp_pkg::ACT_LOAD: begin
                n_wrote  = 1'b1;
                n_dest   = r_e_sel;
                n_result = r_e_ldv;
            end
            arm_dp_pkg::ACT_READ: begin
                n_dest  = r_e_sel;
                n_rdata = sel_val;
            end
            default: begin
                n_executed = 1'b0;
            end
        endcase
    end

    // Write-back into both RAMs as the item leaves the execute stage.
    assign ram_wr_en   = e_fire && n_wrote;
    assign ram_wr_addr = n_dest;
    assign ram_wr_data = n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_valid <= '0;
            r_flags     <= '0;
        end else begin
            if (ram_wr_en) begin
                r_reg_valid[ram_wr_addr] <= 1'b1;
            end
            if (e_fire) begin
                r_flags <= n_flags;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_adv) begin
            r_o_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_o_executed <= n_executed;
            r_o_wrote    <= n_wrote;
            r_o_dest     <= n_dest;
            r_o_result   <= n_result;
            r_o_flags    <= n_flags;
            r_o_rdata    <= n_rdata;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_executed       = r_o_executed;
    assign o_wrote_register = r_o_wrote;
    assign o_dest_index     = r_o_dest;
    assign o_result_value   = r_o_result;
    assign o_flag_n         = r_o_flags[arm_dp_pkg::FLAG_N];
    assign o_flag_z         = r_o_flags[arm_dp_pkg::FLAG_Z];
    assign o_flag_c         = r_o_flags[arm_dp_pkg::FLAG_C];
    assign o_flag_v         = r_o_flags[arm_dp_pkg::FLAG_V];
    assign o_read_data      = r_o_rdata;

    // The register file is only written by an item leaving the execute stage.
    a_write_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_e_valid && e_adv))
        else $error("register write without an advancing item");

    // A forwarding hit only follows a write at the edge the item was read.
    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && $past(in_fire)
            && (r_e_hit_rn || r_e_hit_rm || r_e_hit_rs || r_e_hit_sel))
        |-> $past(ram_wr_en))
        else $error("forwarding hit without a preceding write");

    // No instruction changes the overflow flag.
    a_v_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $stable(r_flags[arm_dp_pkg::FLAG_V]))
        else $error("overflow flag changed");

    // The flags only change when an item completes the execute stage.
    a_flags_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !e_fire |=> $stable(r_flags))
        else $error("flags changed without an item");

endmodule

`default_nettype wire
